// ===== sv/apn_pkg.sv =====
// Shared constants, command codes and width helpers for the peak normalizer.
`default_nettype none
package apn_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned CntW  = $clog2(DataW);

  localparam logic [1:0] CMD_MEASURE = 2'd0;
  localparam logic [1:0] CMD_SCALE   = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] MODE_W8  = 2'd0;
  localparam logic [1:0] MODE_W16 = 2'd1;
  localparam logic [1:0] MODE_W32 = 2'd2;
  localparam logic [1:0] MODE_W64 = 2'd3;
  localparam logic [1:0] MODE_RESET = MODE_W16;

  localparam logic [DataW-1:0] FULL_S8  = 64'h0000_0000_0000_007F;
  localparam logic [DataW-1:0] FULL_S16 = 64'h0000_0000_0000_7FFF;
  localparam logic [DataW-1:0] FULL_S32 = 64'h0000_0000_7FFF_FFFF;
  localparam logic [DataW-1:0] FULL_S64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // Keep the low bits of the configured width and sign-extend them.
  function automatic logic [DataW-1:0] sext_by_mode(input logic [DataW-1:0] x,
                                                    input logic [1:0] mode);
    logic [DataW-1:0] r;
    case (mode)
      MODE_W8:  r = {{56{x[7]}}, x[7:0]};
      MODE_W16: r = {{48{x[15]}}, x[15:0]};
      MODE_W32: r = {{32{x[31]}}, x[31:0]};
      default:  r = x;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] full_scale(input logic [1:0] mode);
    logic [DataW-1:0] r;
    case (mode)
      MODE_W8:  r = FULL_S8;
      MODE_W16: r = FULL_S16;
      MODE_W32: r = FULL_S32;
      default:  r = FULL_S64;
    endcase
    return r;
  endfunction

  // mag << (W-1); mag * full_scale is this minus mag.
  function automatic logic [ProdW-1:0] shift_fs(input logic [DataW-1:0] mag,
                                                input logic [1:0] mode);
    logic [ProdW-1:0] r;
    case (mode)
      MODE_W8:  r = {57'd0, mag, 7'd0};
      MODE_W16: r = {49'd0, mag, 15'd0};
      MODE_W32: r = {33'd0, mag, 31'd0};
      default:  r = {1'b0, mag, 63'd0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/apn_div.sv =====
// Bit-serial restoring divider: 128-by-64 quotient, one quotient bit per cycle.
`default_nettype none
module apn_div
  import apn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DataW-1:0] dividend_hi,
  input  wire logic [DataW-1:0] dividend_lo,
  input  wire logic [DataW-1:0] divisor,
  output logic                  done,
  output logic [DataW-1:0]      quotient
);

  logic             busy_r;
  logic             done_r;
  logic [CntW-1:0]  cnt_r;
  logic [DataW-1:0] rem_r;
  logic [DataW-1:0] dd_r;
  logic [DataW-1:0] q_r;

  logic             carry;
  logic [DataW-1:0] rem_sh;
  logic             take;

  assign carry  = rem_r[DataW-1];
  assign rem_sh = {rem_r[DataW-2:0], dd_r[DataW-1]};
  assign take   = carry || (rem_sh >= divisor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(DataW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend_hi;
      dd_r  <= dividend_lo;
      q_r   <= '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      rem_r <= take ? (rem_sh - divisor) : rem_sh;
      dd_r  <= {dd_r[DataW-2:0], 1'b0};
      q_r   <= {q_r[DataW-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");
`endif

endmodule
`default_nettype wire

// ===== sv/audio_peak_normalizer.sv =====
// Top level of the two-pass audio peak normalizer: control, peak store, output word.
// Usage:
//   Input channel (in_valid / in_stall) carries one word: command, sample and
//   end-of-block flag. A measure word raises the stored peak to |sample|, a clear
//   word zeroes it; neither gives an output word. A scale word gives one output
//   word: sample * full_scale / peak, truncated and saturated to the width set
//   in cfg_sample_width_mode, with out_clipped marking a saturated result.
//   With a zero peak the width-reduced sample passes unchanged.
// Sequence:
//   Measure passes through S_MEAS and back to idle; clear and unused commands
//   finish as the word is taken. A scale word runs product and range setup
//   (S_PLO, S_PHI, S_CHK), the divider at one quotient bit per step, quotient
//   capture (S_DIV), saturation (S_SAT) and output loading (S_FIN), which waits
//   for a free output register; a zero peak skips from S_PLO, and a quotient
//   that cannot fit from S_CHK, to S_FIN. in_stall is high until back in idle.
// Reset (rst_n low, synchronous): peak zero, width 16 bit, output empty.
// Output stall: the finished result waits in the output register; a new input
//   word may still be taken, and the next scale result holds until the
//   register frees up.
`default_nettype none
module audio_peak_normalizer
  import apn_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_cmd,
  input  wire logic signed [DataW-1:0]  in_sample,
  input  wire logic                     in_end_of_block,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DataW-1:0]       out_scaled_sample,
  output logic                          out_block_end_out,
  output logic                          out_clipped,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_sample_width_mode
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MEAS = 8'b0000_0010,
    S_PLO  = 8'b0000_0100,
    S_PHI  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SAT  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       wmode_r, wmode_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [DataW-1:0] peak_r, peak_nxt;
  logic [DataW-1:0] s_r, s_nxt;
  logic [DataW-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             eob_r, eob_nxt;
  logic [DataW-1:0] lo_r, lo_nxt;
  logic [DataW-1:0] hi_r, hi_nxt;
  logic             borrow_r, borrow_nxt;
  logic [DataW-1:0] q_r, q_nxt;
  logic             clip_r, clip_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DataW-1:0] out_data_r, out_data_nxt;
  logic             out_eob_r, out_eob_nxt;
  logic             out_clip_r, out_clip_nxt;

  logic             in_acc;
  logic             out_pop;
  logic [DataW-1:0] in_sext;
  logic [ProdW-1:0] shifted;
  logic [DataW:0]   lo_diff;
  logic [DataW-1:0] limit;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_q;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_pop   = out_valid_r && !out_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_sext   = sext_by_mode(in_sample, wmode_r);
  assign shifted   = shift_fs(mag_r, mode_r);
  assign lo_diff   = {1'b0, shifted[DataW-1:0]} - {1'b0, mag_r};
  assign limit     = full_scale(mode_r) + {{(DataW-1){1'b0}}, neg_r};

  apn_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .dividend_hi (hi_r),
    .dividend_lo (lo_r),
    .divisor     (peak_r),
    .done        (div_done),
    .quotient    (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    wmode_nxt     = wmode_r;
    mode_nxt      = mode_r;
    peak_nxt      = peak_r;
    s_nxt         = s_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    eob_nxt       = eob_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    borrow_nxt    = borrow_r;
    q_nxt         = q_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    out_eob_nxt   = out_eob_r;
    out_clip_nxt  = out_clip_r;
    div_start     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      wmode_nxt = cfg_sample_width_mode;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = wmode_r;
          s_nxt    = in_sext;
          neg_nxt  = in_sext[DataW-1];
          mag_nxt  = in_sext[DataW-1] ? (~in_sext + DataW'(1)) : in_sext;
          eob_nxt  = in_end_of_block;
          case (in_cmd)
            CMD_MEASURE: state_nxt = S_MEAS;
            CMD_SCALE:   state_nxt = S_PLO;
            CMD_CLEAR:   peak_nxt  = '0;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_MEAS: begin
        if (mag_r > peak_r) begin
          peak_nxt = mag_r;
        end
        state_nxt = S_IDLE;
      end
      S_PLO: begin
        if (peak_r == '0) begin
          // pass the sample through untouched
          q_nxt     = s_r;
          neg_nxt   = 1'b0;
          clip_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          lo_nxt     = lo_diff[DataW-1:0];
          borrow_nxt = lo_diff[DataW];
          state_nxt  = S_PHI;
        end
      end
      S_PHI: begin
        hi_nxt    = shifted[ProdW-1:DataW] - {{(DataW-1){1'b0}}, borrow_r};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // quotient would overflow 64 bits: saturate without dividing
        if (hi_r >= peak_r) begin
          q_nxt     = limit;
          clip_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_q;
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (q_r > limit) begin
          q_nxt    = limit;
          clip_nxt = 1'b1;
        end else begin
          clip_nxt = 1'b0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = neg_r ? (~q_r + DataW'(1)) : q_r;
          out_eob_nxt   = eob_r;
          out_clip_nxt  = clip_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wmode_r     <= MODE_RESET;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wmode_r     <= wmode_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    s_r        <= s_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    eob_r      <= eob_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    borrow_r   <= borrow_nxt;
    q_r        <= q_nxt;
    clip_r     <= clip_nxt;
    out_data_r <= out_data_nxt;
    out_eob_r  <= out_eob_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_scaled_sample = $signed(out_data_r);
  assign out_block_end_out = out_eob_r;
  assign out_clipped       = out_clip_r;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (peak_r != '0) && (hi_r < peak_r))
    else $error("divider started with a quotient that cannot fit");
  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && div_done |=> (state_r == S_SAT))
    else $error("divider result not taken");
  a_peak_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> $stable(peak_r))
    else $error("peak changed during a division");
`endif

endmodule
`default_nettype wire
